>>> hw/rtl/calendar_seconds_converter_top_assert.svh
// Assertion macros for the calendar seconds converter. They sample on clock and
// are switched off while reset is high.
`ifndef CALENDAR_SECONDS_CONVERTER_TOP_ASSERT_SVH
`define CALENDAR_SECONDS_CONVERTER_TOP_ASSERT_SVH

// A condition that must hold at every clock edge.
`define CSC_ASSERT_NOW(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define CSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/csc_pkg.sv
package csc_pkg;

   localparam int unsigned DATA_W = 72;

   localparam int unsigned SECS_PER_DAY  = 86400;
   localparam int unsigned SECS_PER_HOUR = 3600;
   localparam int unsigned SECS_PER_MIN  = 60;
   localparam int unsigned MARCH_SHIFT   = 306;
   localparam int unsigned ERA_DAYS      = 1461;
   localparam int unsigned WEEK_DAYS     = 7;
   localparam int unsigned MON_SPAN_NUM  = 5;

   // Division by a constant: the dividend is shifted right by the power of two in
   // the divisor, then multiplied by ceil(2^K / D). K is the dividend width plus
   // ceil(log2(D)), which makes the quotient exact over the whole dividend range.
   localparam int unsigned DAY_PRE  = 7;
   localparam int unsigned DAY_DIV  = SECS_PER_DAY >> DAY_PRE;
   localparam int unsigned DAY_K    = 35;
   localparam logic [25:0] DAY_M    =
      26'(((64'd1 << DAY_K) + 64'(DAY_DIV) - 64'd1) / 64'(DAY_DIV));

   localparam int unsigned HOUR_PRE = 4;
   localparam int unsigned HOUR_DIV = SECS_PER_HOUR >> HOUR_PRE;
   localparam int unsigned HOUR_K   = 21;
   localparam logic [13:0] HOUR_M   =
      14'(((64'd1 << HOUR_K) + 64'(HOUR_DIV) - 64'd1) / 64'(HOUR_DIV));

   localparam int unsigned MIN_PRE  = 2;
   localparam int unsigned MIN_DIV  = SECS_PER_MIN >> MIN_PRE;
   localparam int unsigned MIN_K    = 14;
   localparam logic [10:0] MIN_M    =
      11'(((64'd1 << MIN_K) + 64'(MIN_DIV) - 64'd1) / 64'(MIN_DIV));

   localparam int unsigned WEEK_K   = 19;
   localparam logic [16:0] WEEK_M   =
      17'(((64'd1 << WEEK_K) + 64'(WEEK_DAYS) - 64'd1) / 64'(WEEK_DAYS));

   localparam int unsigned YEAR_K   = 29;
   localparam logic [18:0] YEAR_M   =
      19'(((64'd1 << YEAR_K) + 64'(ERA_DAYS) - 64'd1) / 64'(ERA_DAYS));

   localparam int unsigned MON_DIV  = 153;
   localparam int unsigned MON_K    = 19;
   localparam logic [11:0] MON_M    =
      12'(((64'd1 << MON_K) + 64'(MON_DIV) - 64'd1) / 64'(MON_DIV));

   // Days from the start of a March-based year to the start of month index mi,
   // (153 * mi + 2) / 5.
   function automatic logic [8:0] month_days(input logic [3:0] mi);
      logic [8:0] days;
      case (mi)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd61;
         4'd3:    days = 9'd92;
         4'd4:    days = 9'd122;
         4'd5:    days = 9'd153;
         4'd6:    days = 9'd184;
         4'd7:    days = 9'd214;
         4'd8:    days = 9'd245;
         4'd9:    days = 9'd275;
         4'd10:   days = 9'd306;
         4'd11:   days = 9'd337;
         4'd12:   days = 9'd367;
         4'd13:   days = 9'd398;
         4'd14:   days = 9'd428;
         4'd15:   days = 9'd459;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

   typedef struct packed {
      logic        func;
      logic [31:0] seconds;
      logic [50:0] day_prod;
      logic [7:0]  ya;
      logic [3:0]  mi;
      logic [4:0]  day;
      logic [16:0] hms;
   } s1_type;

   typedef struct packed {
      logic        func;
      logic [15:0] days;
      logic [16:0] rem;
      logic [31:0] dsum;
      logic [16:0] hms;
   } s2_type;

   typedef struct packed {
      logic        func;
      logic [16:0] rem;
      logic [15:0] t2;
      logic [26:0] hour_prod;
      logic [36:0] year_prod;
      logic [33:0] week_prod;
      logic [31:0] dprod;
      logic [16:0] hms;
   } s3_type;

   typedef struct packed {
      logic        func;
      logic [4:0]  hour;
      logic [11:0] hrem;
      logic [7:0]  ya;
      logic [2:0]  wd;
      logic [15:0] t2;
      logic [31:0] seconds;
   } s4_type;

   typedef struct packed {
      logic        func;
      logic [4:0]  hour;
      logic [11:0] hrem;
      logic [7:0]  ya;
      logic [2:0]  wd;
      logic [20:0] min_prod;
      logic [8:0]  t3;
      logic [31:0] seconds;
   } s5_type;

   typedef struct packed {
      logic        func;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [7:0]  ya;
      logic [2:0]  wd;
      logic [8:0]  t3;
      logic [22:0] mon_prod;
      logic [31:0] seconds;
   } s6_type;

endpackage

>>> hw/rtl/calendar_seconds_converter_top.sv
// Converts between a seconds count since 2000-01-01 00:00:00 and calendar time.
// With tuser 0 the date and time fields are folded into a seconds count; with
// tuser 1 a seconds count is split into year, month, day, hour, minute, second
// and weekday. The block accepts one transfer per clock while rsp_tready is high,
// and each transfer gives one result transfer through six arithmetic stages
// (each holding one multiply-by-reciprocal, or the subtract that recovers its
// remainder) and the output register. Each stage stalls only when the stage
// after it is full and stalled, so bubbles are squeezed out under backpressure.
`include "calendar_seconds_converter_top_assert.svh"

module calendar_seconds_converter_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // seconds_in[31:0], year_in[39:32], month_in[43:40], day_in[48:44],
   // hour_in[53:49], minute_in[59:54], second_in[65:60], zero fill above.
   input  logic [csc_pkg::DATA_W-1:0] req_tdata,
   // func[0].
   input  logic [0:0]                 req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // seconds_out[31:0], year_out[39:32], month_out[43:40], day_out[48:44],
   // hour_out[53:49], minute_out[59:54], second_out[65:60],
   // weekday_out[68:66], zero fill above.
   output logic [csc_pkg::DATA_W-1:0] rsp_tdata
);

   localparam int unsigned STAGES = 7;

   logic [STAGES-1:0]          stage_vld_ff;
   logic [STAGES-1:0]          adv;
   csc_pkg::s1_type            s1_ff, s1_in;
   csc_pkg::s2_type            s2_ff, s2_in;
   csc_pkg::s3_type            s3_ff, s3_in;
   csc_pkg::s4_type            s4_ff, s4_in;
   csc_pkg::s5_type            s5_ff, s5_in;
   csc_pkg::s6_type            s6_ff, s6_in;
   logic [csc_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [3:0]  in_month;
   logic        in_early;
   logic [13:0] week_q;
   logic [10:0] mon_x;
   logic [3:0]  out_mi;
   logic        out_early;
   logic [7:0]  out_year;
   logic [3:0]  out_month;
   logic [4:0]  out_day;

   // A stage moves on when it is empty or the stage after it moves on.
   always_comb begin
      adv[STAGES-1] = !stage_vld_ff[STAGES-1] || rsp_tready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         adv[i] = !stage_vld_ff[i] || adv[i+1];
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = stage_vld_ff[STAGES-1];
   assign rsp_tdata  = rsp_data_ff;

   // Stage 1: day quotient product; date path prepares year and month indexes and the seconds of the day.
   always_comb begin
      in_month       = req_tdata[43:40];
      in_early       = in_month < 4'd3;
      s1_in.func     = req_tuser[0];
      s1_in.seconds  = req_tdata[31:0];
      s1_in.day_prod = 51'(req_tdata[31:csc_pkg::DAY_PRE]) * 51'(csc_pkg::DAY_M);
      s1_in.ya       = req_tdata[39:32] + 8'd1 - {7'd0, in_early};
      s1_in.mi       = in_early ? in_month + 4'd9 : in_month - 4'd3;
      s1_in.day      = req_tdata[48:44];
      s1_in.hms      = 17'(req_tdata[53:49]) * 17'(csc_pkg::SECS_PER_HOUR)
                     + 17'(req_tdata[59:54]) * 17'(csc_pkg::SECS_PER_MIN)
                     + 17'(req_tdata[65:60]);
   end

   // Stage 2: day count and seconds within the day; date path sums its days.
   always_comb begin
      s2_in.func = s1_ff.func;
      s2_in.days = 16'(s1_ff.day_prod >> csc_pkg::DAY_K);
      s2_in.rem  = 17'(s1_ff.seconds - 32'(s2_in.days) * 32'(csc_pkg::SECS_PER_DAY));
      s2_in.dsum = 32'(s1_ff.day) - 32'd1 + 32'(csc_pkg::month_days(s1_ff.mi))
                 + 32'((19'(csc_pkg::ERA_DAYS) * 19'(s1_ff.ya) + 19'd3) >> 2)
                 - 32'(csc_pkg::MARCH_SHIFT);
      s2_in.hms  = s1_ff.hms;
   end

   // Stage 3: quotient products for hour, year and weekday; date path scales its days to seconds.
   always_comb begin
      s3_in.func      = s2_ff.func;
      s3_in.rem       = s2_ff.rem;
      s3_in.t2        = s2_ff.days + 16'(csc_pkg::MARCH_SHIFT);
      s3_in.hour_prod = 27'(s2_ff.rem >> csc_pkg::HOUR_PRE) * 27'(csc_pkg::HOUR_M);
      s3_in.year_prod = 37'({s3_in.t2, 2'b00}) * 37'(csc_pkg::YEAR_M);
      s3_in.week_prod = (34'(s3_in.t2) + 34'd1) * 34'(csc_pkg::WEEK_M);
      s3_in.dprod     = s2_ff.dsum * 32'(csc_pkg::SECS_PER_DAY);
      s3_in.hms       = s2_ff.hms;
   end

   // Stage 4: hour, year index and weekday; date path finishes its count.
   always_comb begin
      week_q        = 14'(s3_ff.week_prod >> csc_pkg::WEEK_K);
      s4_in.func    = s3_ff.func;
      s4_in.hour    = 5'(s3_ff.hour_prod >> csc_pkg::HOUR_K);
      s4_in.hrem    = 12'(s3_ff.rem - 17'(s4_in.hour) * 17'(csc_pkg::SECS_PER_HOUR));
      s4_in.ya      = 8'(s3_ff.year_prod >> csc_pkg::YEAR_K);
      s4_in.wd      = 3'(17'(s3_ff.t2) + 17'd1 - 17'(week_q) * 17'(csc_pkg::WEEK_DAYS));
      s4_in.t2      = s3_ff.t2;
      s4_in.seconds = s3_ff.dprod + 32'(s3_ff.hms);
   end

   // Stage 5: minute product and day within the March-based year.
   always_comb begin
      s5_in.func     = s4_ff.func;
      s5_in.hour     = s4_ff.hour;
      s5_in.hrem     = s4_ff.hrem;
      s5_in.ya       = s4_ff.ya;
      s5_in.wd       = s4_ff.wd;
      s5_in.min_prod = 21'(s4_ff.hrem >> csc_pkg::MIN_PRE) * 21'(csc_pkg::MIN_M);
      s5_in.t3       = 9'(19'(s4_ff.t2)
                     - ((19'(csc_pkg::ERA_DAYS) * 19'(s4_ff.ya) + 19'd3) >> 2));
      s5_in.seconds  = s4_ff.seconds;
   end

   // Stage 6: minute and second; month quotient product.
   always_comb begin
      mon_x          = 11'(s5_ff.t3) * 11'(csc_pkg::MON_SPAN_NUM) + 11'd2;
      s6_in.func     = s5_ff.func;
      s6_in.hour     = s5_ff.hour;
      s6_in.minute   = 6'(s5_ff.min_prod >> csc_pkg::MIN_K);
      s6_in.second   = 6'(s5_ff.hrem - 12'(s6_in.minute) * 12'(csc_pkg::SECS_PER_MIN));
      s6_in.ya       = s5_ff.ya;
      s6_in.wd       = s5_ff.wd;
      s6_in.t3       = s5_ff.t3;
      s6_in.mon_prod = 23'(mon_x) * 23'(csc_pkg::MON_M);
      s6_in.seconds  = s5_ff.seconds;
   end

   // Output stage: month, day and calendar year, then the result is packed.
   always_comb begin
      out_mi    = 4'(s6_ff.mon_prod >> csc_pkg::MON_K);
      out_early = out_mi < 4'd10;
      out_day   = 5'(s6_ff.t3 - csc_pkg::month_days(out_mi) + 9'd1);
      out_year  = s6_ff.ya - {7'd0, out_early};
      out_month = out_early ? out_mi + 4'd3 : out_mi - 4'd9;
      if (s6_ff.func) begin
         rsp_data_in = {3'd0, s6_ff.wd, s6_ff.second, s6_ff.minute, s6_ff.hour,
                        out_day, out_month, out_year, 32'd0};
      end else begin
         rsp_data_in = {40'd0, s6_ff.seconds};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            stage_vld_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < STAGES; i++) begin
            if (adv[i]) begin
               stage_vld_ff[i] <= stage_vld_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_ff <= s1_in;
      end
      if (adv[1]) begin
         s2_ff <= s2_in;
      end
      if (adv[2]) begin
         s3_ff <= s3_in;
      end
      if (adv[3]) begin
         s4_ff <= s4_in;
      end
      if (adv[4]) begin
         s5_ff <= s5_in;
      end
      if (adv[5]) begin
         s6_ff <= s6_in;
      end
      if (adv[6]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `CSC_ASSERT_NEXT(a_accept_fills_stage, req_tvalid && req_tready, stage_vld_ff[0],
      "Accepted transfer did not enter the first stage.")
   `CSC_ASSERT_NEXT(a_blocked_stage_holds, stage_vld_ff[0] && !adv[1], stage_vld_ff[0],
      "First stage lost its item while blocked.")
   `CSC_ASSERT_NOW(a_one_result_kind,
      !rsp_tvalid || (rsp_tdata[31:0] == 32'd0) || (rsp_tdata[68:32] == 37'd0),
      "Result carries both a seconds count and date fields.")
   `CSC_ASSERT_NOW(a_date_in_range,
      !rsp_tvalid || (rsp_tdata[43:40] == 4'd0) || ((rsp_tdata[43:40] <= 4'd12)
      && (rsp_tdata[48:44] != 5'd0) && (rsp_tdata[53:49] <= 5'd23)
      && (rsp_tdata[59:54] <= 6'd59) && (rsp_tdata[65:60] <= 6'd59)
      && (rsp_tdata[68:66] <= 3'd6)),
      "Date result field out of range.")

endmodule
